[design/mlmd_pkg.sv]
// Shared types and constants for the marker/length message deframer.
// No dependencies; imported by every module of the block.
`default_nettype none
package mlmd_pkg;

  localparam int MARKER_BYTES_DEF     = 16;
  localparam int OPEN_FIXED_BYTES_DEF = 10;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam int LEN_W  = 16;
  localparam int EXT_W  = 8;
  localparam int CODE_W = 3;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [7:0] OPEN_TYPE   = 8'h01;

  typedef logic [CODE_W-1:0] err_code_t;

  localparam err_code_t ERR_BAD_MARKER   = 3'd0;
  localparam err_code_t ERR_LEN_TINY     = 3'd1;
  localparam err_code_t ERR_OPEN_SHORT   = 3'd2;
  localparam err_code_t ERR_NOT_OPEN     = 3'd3;
  localparam err_code_t ERR_EXT_OVERRUN  = 3'd4;
  localparam err_code_t ERR_EMPTY_PAYLD  = 3'd5;
  localparam err_code_t ERR_NONE         = 3'd0;

  // one result word
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_message;
    logic       is_error;
    err_code_t  error_code;
  } res_t;

  // front-to-queue write
  typedef struct packed {
    logic push;
    res_t res;
  } res_push_t;

endpackage
`default_nettype wire

[design/mlmd_front.sv]
// Front part: header parser that classifies each accepted byte.
// Depends on mlmd_pkg; writes result words into mlmd_queue.
`default_nettype none
module mlmd_front import mlmd_pkg::*; #(
  parameter int MARKER_BYTES     = MARKER_BYTES_DEF,
  parameter int OPEN_FIXED_BYTES = OPEN_FIXED_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       connection_start,
  input  wire logic       length_big_endian,
  output res_push_t       wr
);

  typedef enum logic [5:0] {
    PH_MARKER  = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_OPEN    = 6'b001000,
    PH_EXT     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t             phase_r, phase_nxt, phase_cur;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt, cnt_cur, cnt_inc;
  logic [LEN_W-1:0]   len_r, len_nxt, len_cur, len_full;
  logic               open_r, open_nxt, open_cur;
  logic [EXT_W-1:0]   ext_r, ext_nxt, ext_cur;
  logic               rej_r, rej_nxt, rej_cur;
  logic [LEN_W:0]     rest;
  logic [LEN_W:0]     b_wide;

  always_comb begin
    // a new connection clears everything before this byte is handled
    phase_cur = connection_start ? PH_MARKER : phase_r;
    cnt_cur   = connection_start ? '0 : cnt_r;
    len_cur   = connection_start ? '0 : len_r;
    open_cur  = connection_start ? 1'b0 : open_r;
    ext_cur   = connection_start ? '0 : ext_r;
    rej_cur   = connection_start ? 1'b0 : rej_r;

    cnt_inc  = cnt_cur + LEN_W'(1);
    len_full = length_big_endian ? (len_cur | {8'h00, data_byte})
                                 : (len_cur | {data_byte, 8'h00});
    rest     = {1'b0, len_cur} - (LEN_W+1)'(OPEN_FIXED_BYTES + 1);
    b_wide   = {{(LEN_W-7){1'b0}}, data_byte};

    phase_nxt = phase_cur;
    cnt_nxt   = cnt_cur;
    len_nxt   = len_cur;
    open_nxt  = open_cur;
    ext_nxt   = ext_cur;
    rej_nxt   = rej_cur;

    wr.push                = 1'b0;
    wr.res.payload_byte    = 8'h00;
    wr.res.last_of_message = 1'b0;
    wr.res.is_error        = 1'b1;
    wr.res.error_code      = ERR_NONE;

    if (!rej_cur) begin
      unique case (phase_cur)
        PH_MARKER: begin
          if (data_byte != MARKER_BYTE) begin
            wr.push = 1'b1;
            wr.res.error_code = ERR_BAD_MARKER;
          end else if (cnt_inc >= LEN_W'(MARKER_BYTES)) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_LEN: begin
          if (cnt_cur == '0) begin
            len_nxt = length_big_endian ? {data_byte, 8'h00} : {8'h00, data_byte};
            cnt_nxt = LEN_W'(1);
          end else begin
            len_nxt = len_full;
            cnt_nxt = '0;
            if (len_full <= LEN_W'(1)) begin
              wr.push = 1'b1;
              wr.res.error_code = ERR_LEN_TINY;
            end else if (!open_cur && len_full < LEN_W'(OPEN_FIXED_BYTES + 1)) begin
              wr.push = 1'b1;
              wr.res.error_code = ERR_OPEN_SHORT;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          cnt_nxt = LEN_W'(1);
          if (open_cur) begin
            phase_nxt = PH_PAYLOAD;
          end else if (data_byte != OPEN_TYPE) begin
            wr.push = 1'b1;
            wr.res.error_code = ERR_NOT_OPEN;
          end else begin
            open_nxt  = 1'b1;
            phase_nxt = PH_OPEN;
          end
        end
        PH_OPEN: begin
          if (cnt_cur < LEN_W'(OPEN_FIXED_BYTES)) begin
            cnt_nxt = cnt_inc;
          end else if (b_wide > rest) begin
            wr.push = 1'b1;
            wr.res.error_code = ERR_EXT_OVERRUN;
          end else if (b_wide == rest) begin
            wr.push = 1'b1;
            wr.res.error_code = ERR_EMPTY_PAYLD;
          end else begin
            // extension count byte
            cnt_nxt   = cnt_inc;
            ext_nxt   = data_byte;
            phase_nxt = (data_byte != 8'h00) ? PH_EXT : PH_PAYLOAD;
          end
        end
        PH_EXT: begin
          cnt_nxt = cnt_inc;
          ext_nxt = ext_cur - EXT_W'(1);
          if (ext_nxt == '0) phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          wr.push                = 1'b1;
          wr.res.payload_byte    = data_byte;
          wr.res.is_error        = 1'b0;
          if (cnt_inc >= len_cur) begin
            wr.res.last_of_message = 1'b1;
            phase_nxt = PH_MARKER;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = PH_MARKER;
          cnt_nxt   = '0;
        end
      endcase
      if (wr.push && wr.res.is_error) rej_nxt = 1'b1;
    end
    wr.push = wr.push & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARKER;
      cnt_r   <= '0;
      len_r   <= '0;
      open_r  <= 1'b0;
      ext_r   <= '0;
      rej_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      open_r  <= open_nxt;
      ext_r   <= ext_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule
`default_nettype wire

[design/mlmd_queue.sv]
// Back part: short result queue that presents the oldest word to the output.
// Depends on mlmd_pkg.
`default_nettype none
module mlmd_queue import mlmd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_push_t wr,
  input  wire logic      pop,
  output logic           full,
  output logic           empty,
  output res_t           head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign head   = mem[rp_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr.push) wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    if (do_pop)  rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    if (wr.push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!wr.push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wr.push) mem[wp_r] <= wr.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[design/marker_length_message_deframer_top.sv]
// Top level of the marker/length message deframer.
// Depends on mlmd_pkg, mlmd_front and mlmd_queue.
//
// channel  | direction | handshake            | words
// ---------+-----------+----------------------+---------------------------------------
// in_      | in        | in_push / in_full    | data_byte, connection_start
// out_     | out       | out_pop / out_empty  | payload_byte, last, is_error, code
// cfg_     | in        | cfg_valid / cfg_ready| length_big_endian
//
// One input word per cycle, back to back while in_full is low; the parser settles
// each byte in the cycle it is accepted and writes its result (if any) to the queue.
// in_full rises only when the result queue (QUEUE_DEPTH words) is full; the
// parser advances only on accepted words, so output stalls never lose state.
// Reset (rst_n low, synchronous) empties the queue, clears the parser and sets
// length_big_endian to 0. cfg_ready is always high.
`default_nettype none
module marker_length_message_deframer_top import mlmd_pkg::*; #(
  parameter int MARKER_BYTES     = MARKER_BYTES_DEF,
  parameter int OPEN_FIXED_BYTES = OPEN_FIXED_BYTES_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_connection_start,
  // results
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_payload_byte,
  output logic             out_last_of_message,
  output logic             out_is_error,
  output logic [CODE_W-1:0] out_error_code,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_length_big_endian
);

  logic      be_r;
  logic      accept;
  res_push_t wr;
  res_t      head;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  // byte order of the length field
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      be_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      be_r <= cfg_length_big_endian;
    end
  end

  mlmd_front #(
    .MARKER_BYTES     (MARKER_BYTES),
    .OPEN_FIXED_BYTES (OPEN_FIXED_BYTES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .data_byte         (in_data_byte),
    .connection_start  (in_connection_start),
    .length_big_endian (be_r),
    .wr                (wr)
  );

  mlmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (out_pop),
    .full  (in_full),
    .empty (out_empty),
    .head  (head)
  );

  assign out_payload_byte    = head.payload_byte;
  assign out_last_of_message = head.last_of_message;
  assign out_is_error        = head.is_error;
  assign out_error_code      = head.error_code;

endmodule
`default_nettype wire

[design/mlmd_checker.sv]
// Port-level checker for the deframer top, with its bind.
// Depends on mlmd_pkg and marker_length_message_deframer_top.
`default_nettype none
module mlmd_checker import mlmd_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_push,
  input wire logic              in_full,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire logic [7:0]        out_payload_byte,
  input wire logic              out_last_of_message,
  input wire logic              out_is_error,
  input wire logic [CODE_W-1:0] out_error_code
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("queue not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty && !(in_push && !in_full) |=> out_empty)
    else $error("result appeared without an accepted byte");

  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty |-> !in_full)
    else $error("input stalled while no result is waiting");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_is_error |->
      out_payload_byte == 8'h00 && !out_last_of_message && out_error_code <= ERR_EMPTY_PAYLD)
    else $error("malformed error word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_payload_byte) &&
      $stable(out_is_error) && $stable(out_error_code))
    else $error("stalled result changed");

endmodule

bind marker_length_message_deframer_top mlmd_checker u_mlmd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_push             (in_push),
  .in_full             (in_full),
  .out_empty           (out_empty),
  .out_pop             (out_pop),
  .out_payload_byte    (out_payload_byte),
  .out_last_of_message (out_last_of_message),
  .out_is_error        (out_is_error),
  .out_error_code      (out_error_code)
);
`default_nettype wire
